// File: design/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press reporting.
// Holds the beat payload structs, the configuration struct and register indexes.
// No dependencies.
`default_nettype none

package bdlp_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  // Register indexes (byte address is four times the index).
  localparam logic [CfgIdxW-1:0] REG_IDLE_LEVEL      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FILTER_MS       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_MS   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_INTERVAL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_EN   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_REP  = 3'd5;

  // Register reset values.
  localparam logic        RST_IDLE_LEVEL      = 1'b1;
  localparam logic [15:0] RST_FILTER_MS       = 16'd20;
  localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd1000;
  localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd200;
  localparam logic        RST_LONG_PRESS_EN   = 1'b0;
  localparam logic        RST_LONG_PRESS_REP  = 1'b0;

  // One poll of the pin.
  typedef struct packed {
    logic        pin_sample;
    logic [31:0] now_ms;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic rise_event;
    logic fall_event;
    logic click_event;
    logic long_press_event;
    logic release_event;
    logic raw_level;
  } out_item_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic        idle_level;
    logic [15:0] filter_ms;
    logic [15:0] long_press_ms;
    logic [15:0] repeat_interval_ms;
    logic        long_press_enable;
    logic        long_press_repeat;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/button_debounce_long_press.sv
// Top level of the button debouncer with click, long-press and release reporting.
// Instantiates bdlp_cfg and bdlp_core; uses bdlp_pkg for beat and config types.
//
//   Channel   Direction  Handshake                Payload
//   in_       input      in_valid / in_stall      in_item  (in_item_t)
//   out_      output     out_valid / out_stall    out_item (out_item_t)
//   cfg_      input      APB-style, pready high   6 registers at 4*index
//
// One poll is taken every cycle while the output is not stalled; each poll yields exactly one result beat.
// A poll passes through an input register, then the datapath into the result register.
// The state update and the result share one cycle, so consecutive polls never wait.
// Reset is synchronous on rst_n and needs no clearing pass.
// A stall on the output holds the result register and then the input register.
`default_nettype none

module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_item,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic      [CfgDataW-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;
  logic      step;

  assign cfg_pready = 1'b1;

  bdlp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // The result register can take a new beat when empty or being drained.
  assign advance  = ~out_valid_r | ~out_stall;
  assign step     = advance & in_valid_r;
  assign in_stall = in_valid_r & ~advance;

  bdlp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A beat accepted at the input always lands in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_valid_r)
    else $error("accepted input beat was not captured");

  // A held input beat must stall the input side while the output is blocked.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input not stalled while result register is blocked");

  // The filtered level flips at most one way per poll.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.rise_event && out_item_r.fall_event))
    else $error("rise and fall reported on the same poll");

  // Click and long-press reporting are exclusive.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.click_event && out_item_r.long_press_event))
    else $error("click and long press reported on the same poll");

endmodule

`default_nettype wire

// File: design/bdlp_cfg.sv
// Configuration register file with an APB-style access port.
// Depends on bdlp_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module bdlp_cfg
  import bdlp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output cfg_t                     cfg
);

  cfg_t              cfg_r;
  logic              wr_en;
  logic [CfgIdxW-1:0] idx;

  assign idx   = paddr[CfgAddrW-1:2];
  assign wr_en = psel & penable & pwrite;

  // Register writes; the byte offset within a word is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_level         <= RST_IDLE_LEVEL;
      cfg_r.filter_ms          <= RST_FILTER_MS;
      cfg_r.long_press_ms      <= RST_LONG_PRESS_MS;
      cfg_r.repeat_interval_ms <= RST_REPEAT_INTERVAL;
      cfg_r.long_press_enable  <= RST_LONG_PRESS_EN;
      cfg_r.long_press_repeat  <= RST_LONG_PRESS_REP;
    end else if (wr_en) begin
      case (idx)
        REG_IDLE_LEVEL:      cfg_r.idle_level         <= pwdata[0];
        REG_FILTER_MS:       cfg_r.filter_ms          <= pwdata[15:0];
        REG_LONG_PRESS_MS:   cfg_r.long_press_ms      <= pwdata[15:0];
        REG_REPEAT_INTERVAL: cfg_r.repeat_interval_ms <= pwdata[15:0];
        REG_LONG_PRESS_EN:   cfg_r.long_press_enable  <= pwdata[0];
        REG_LONG_PRESS_REP:  cfg_r.long_press_repeat  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux, zero-extended to the bus width.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_IDLE_LEVEL:      prdata[0]    = cfg_r.idle_level;
      REG_FILTER_MS:       prdata[15:0] = cfg_r.filter_ms;
      REG_LONG_PRESS_MS:   prdata[15:0] = cfg_r.long_press_ms;
      REG_REPEAT_INTERVAL: prdata[15:0] = cfg_r.repeat_interval_ms;
      REG_LONG_PRESS_EN:   prdata[0]    = cfg_r.long_press_enable;
      REG_LONG_PRESS_REP:  prdata[0]    = cfg_r.long_press_repeat;
      default:             prdata       = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/bdlp_core.sv
// Debounce and press classification datapath with its state registers.
// Computes one result per poll and updates state when the poll is consumed.
// Depends on bdlp_pkg for in_item_t, out_item_t and cfg_t.
`default_nettype none

module bdlp_core
  import bdlp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  logic        filtered_level_r, filtered_level_nxt;
  logic        change_pending_r, change_pending_nxt;
  logic [31:0] change_time_r,    change_time_nxt;
  logic        press_seen_r,     press_seen_nxt;
  logic        long_done_r,      long_done_nxt;
  logic [31:0] long_report_r,    long_report_nxt;

  logic        differs;
  logic        stamp;
  logic        held;
  logic        accept;
  logic [31:0] since_change;
  logic [31:0] since_report;

  assign since_change = item.now_ms - change_time_r;
  assign since_report = item.now_ms - long_report_r;
  assign differs      = item.pin_sample != filtered_level_r;
  // A fresh stamp means zero elapsed time, which never beats the filter.
  assign stamp        = differs & ~change_pending_r;
  assign held         = ~stamp & (since_change > {16'd0, cfg.filter_ms});
  assign accept       = differs & change_pending_r & held;

  // Next state and result for the current poll.
  always_comb begin
    filtered_level_nxt = filtered_level_r;
    change_pending_nxt = change_pending_r;
    change_time_nxt    = change_time_r;
    press_seen_nxt     = press_seen_r;
    long_done_nxt      = long_done_r;
    long_report_nxt    = long_report_r;
    result             = '0;
    result.raw_level   = item.pin_sample;

    // Filter: open a pending change, or accept it once it has persisted.
    if (stamp) begin
      change_time_nxt    = item.now_ms;
      change_pending_nxt = 1'b1;
    end else if (accept) begin
      filtered_level_nxt = ~filtered_level_r;
      change_pending_nxt = 1'b0;
      result.rise_event  = ~filtered_level_r;
      result.fall_event  = filtered_level_r;
    end

    // Drop an old pending change when the pin is back at rest.
    if (held && change_pending_nxt && (item.pin_sample == cfg.idle_level)) begin
      change_pending_nxt = 1'b0;
    end

    // Press classification against the updated filtered level.
    if (filtered_level_nxt == cfg.idle_level) begin
      result.release_event = press_seen_r & ~long_done_r;
      press_seen_nxt       = 1'b0;
    end else if (held) begin
      if (cfg.long_press_enable) begin
        if (since_change < {16'd0, cfg.long_press_ms}) begin
          press_seen_nxt  = 1'b1;
          long_done_nxt   = 1'b0;
          long_report_nxt = item.now_ms;
        end else if (!cfg.long_press_repeat) begin
          if (!long_done_r) begin
            long_done_nxt           = 1'b1;
            result.long_press_event = 1'b1;
          end
        end else if (since_report > {16'd0, cfg.repeat_interval_ms}) begin
          long_report_nxt         = item.now_ms;
          long_done_nxt           = 1'b1;
          result.long_press_event = 1'b1;
        end
      end else if (!press_seen_r) begin
        press_seen_nxt     = 1'b1;
        result.click_event = 1'b1;
      end
    end
  end

  // State registers advance only when a poll is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filtered_level_r <= RST_IDLE_LEVEL;
      change_pending_r <= 1'b0;
      change_time_r    <= '0;
      press_seen_r     <= 1'b0;
      long_done_r      <= 1'b0;
      long_report_r    <= '0;
    end else if (step) begin
      filtered_level_r <= filtered_level_nxt;
      change_pending_r <= change_pending_nxt;
      change_time_r    <= change_time_nxt;
      press_seen_r     <= press_seen_nxt;
      long_done_r      <= long_done_nxt;
      long_report_r    <= long_report_nxt;
    end
  end

endmodule

`default_nettype wire

// File: dv/bdlp_checker.sv
// Result checker for the button debouncer: predicts one report per accepted poll.
// Watches the poll, report and configuration channels of button_debounce_long_press.
// Depends on bdlp_pkg for the beat structs, register indexes and reset values.

module bdlp_checker
  import bdlp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire in_item_t            in_item,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire out_item_t           out_item,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic                cfg_pready,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output int unsigned              fail_count,
  output int unsigned              reports_due
);

  timeunit 1ns;
  timeprecision 1ps;

  // Register mirror and debouncer state.
  cfg_t        mirror;
  logic        filt_level;
  logic        chg_pending;
  logic [31:0] chg_stamp;
  logic        press_seen;
  logic        long_done;
  logic [31:0] report_stamp;

  out_item_t   pending_reports[$];
  int unsigned mismatches;
  int unsigned beats_seen;

  // Advances the debouncer by one poll and returns the report it produces.
  task automatic debounce_poll(input in_item_t poll, output out_item_t beat);
    logic        pin;
    logic [31:0] now;
    logic [31:0] age;
    pin  = poll.pin_sample;
    now  = poll.now_ms;
    beat = '0;
    beat.raw_level = pin;

    // A differing pin opens a pending change, or accepts one that has aged out.
    if (pin != filt_level) begin
      age = now - chg_stamp;
      if (!chg_pending) begin
        chg_stamp   = now;
        chg_pending = 1'b1;
      end else if (age > mirror.filter_ms) begin
        if (filt_level) begin
          filt_level      = 1'b0;
          beat.fall_event = 1'b1;
        end else begin
          filt_level      = 1'b1;
          beat.rise_event = 1'b1;
        end
        chg_pending = 1'b0;
      end
    end

    // An aged pending change is dropped only when the pin is back at rest.
    age = now - chg_stamp;
    if (age > mirror.filter_ms && chg_pending && pin == mirror.idle_level) begin
      chg_pending = 1'b0;
    end

    // Press, long press and release reporting.
    if (filt_level == mirror.idle_level) begin
      if (press_seen && !long_done) begin
        beat.release_event = 1'b1;
      end
      press_seen = 1'b0;
    end else if (age > mirror.filter_ms) begin
      if (mirror.long_press_enable) begin
        if (age < mirror.long_press_ms) begin
          press_seen   = 1'b1;
          long_done    = 1'b0;
          report_stamp = now;
        end else if (!mirror.long_press_repeat) begin
          if (!long_done) begin
            long_done             = 1'b1;
            beat.long_press_event = 1'b1;
          end
        end else if (now - report_stamp > mirror.repeat_interval_ms) begin
          report_stamp          = now;
          long_done             = 1'b1;
          beat.long_press_event = 1'b1;
        end
      end else if (!press_seen) begin
        press_seen       = 1'b1;
        beat.click_event = 1'b1;
      end
    end
  endtask

  // Compares one report field; only the first few mismatches are printed.
  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("bdlp_checker: report %0d field %s expected %0b got %0b",
                 beats_seen, field, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      mirror.idle_level         = RST_IDLE_LEVEL;
      mirror.filter_ms          = RST_FILTER_MS;
      mirror.long_press_ms      = RST_LONG_PRESS_MS;
      mirror.repeat_interval_ms = RST_REPEAT_INTERVAL;
      mirror.long_press_enable  = RST_LONG_PRESS_EN;
      mirror.long_press_repeat  = RST_LONG_PRESS_REP;
      filt_level   = RST_IDLE_LEVEL;
      chg_pending  = 1'b0;
      chg_stamp    = '0;
      press_seen   = 1'b0;
      long_done    = 1'b0;
      report_stamp = '0;
      pending_reports.delete();
      mismatches   = 0;
      beats_seen   = 0;
    end else begin
      // Register writes land on the access cycle; bits above each width are dropped.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CfgAddrW-1:2])
          REG_IDLE_LEVEL:      mirror.idle_level         = cfg_pwdata[0];
          REG_FILTER_MS:       mirror.filter_ms          = cfg_pwdata[15:0];
          REG_LONG_PRESS_MS:   mirror.long_press_ms      = cfg_pwdata[15:0];
          REG_REPEAT_INTERVAL: mirror.repeat_interval_ms = cfg_pwdata[15:0];
          REG_LONG_PRESS_EN:   mirror.long_press_enable  = cfg_pwdata[0];
          REG_LONG_PRESS_REP:  mirror.long_press_repeat  = cfg_pwdata[0];
          default: ;
        endcase
      end

      // Each report beat is matched against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          if (mismatches < 10) begin
            $display("bdlp_checker: report %0d arrived with no poll waiting", beats_seen);
          end
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("rise_event", want.rise_event, out_item.rise_event);
          check_field("fall_event", want.fall_event, out_item.fall_event);
          check_field("click_event", want.click_event, out_item.click_event);
          check_field("long_press_event", want.long_press_event, out_item.long_press_event);
          check_field("release_event", want.release_event, out_item.release_event);
          check_field("raw_level", want.raw_level, out_item.raw_level);
        end
        beats_seen++;
      end

      // Each accepted poll queues the report it should produce.
      if (in_valid && !in_stall) begin
        debounce_poll(in_item, fresh);
        pending_reports.push_back(fresh);
      end
    end
    fail_count  <= mismatches;
    reports_due <= pending_reports.size();
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for button_debounce_long_press: clock, reset, polls, register writes.
// Instantiates the block and bdlp_checker, and prints the verdict.
// Depends on bdlp_pkg, bdlp_checker and the block's RTL.

module tb_top;

  import bdlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned PhasePolls    = 88;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  in_item_t            in_item     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  out_item_t           out_item;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [CfgDataW-1:0] cfg_pwdata  = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  int unsigned fail_count;
  int unsigned reports_due;
  int unsigned polls_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  logic [31:0] ms_clock     = '0;
  cfg_t        knobs;

  always #6 clk = ~clk;

  button_debounce_long_press i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bdlp_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .reports_due (reports_due)
  );

  // Watchdog: ends the run when no beat and no register access has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_knobs(input logic idle, input logic [15:0] filt, input logic [15:0] hold,
                           input logic [15:0] spacing, input logic en, input logic rep);
    knobs.idle_level         = idle;
    knobs.filter_ms          = filt;
    knobs.long_press_ms      = hold;
    knobs.repeat_interval_ms = spacing;
    knobs.long_press_enable  = en;
    knobs.long_press_repeat  = rep;
  endtask

  // Writes every register, with random junk above each field's width.
  task automatic apply_knobs();
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_IDLE_LEVEL, {junk[31:1], knobs.idle_level});
    junk = $urandom;
    write_reg(REG_FILTER_MS, {junk[31:16], knobs.filter_ms});
    junk = $urandom;
    write_reg(REG_LONG_PRESS_MS, {junk[31:16], knobs.long_press_ms});
    junk = $urandom;
    write_reg(REG_REPEAT_INTERVAL, {junk[31:16], knobs.repeat_interval_ms});
    junk = $urandom;
    write_reg(REG_LONG_PRESS_EN, {junk[31:1], knobs.long_press_enable});
    junk = $urandom;
    write_reg(REG_LONG_PRESS_REP, {junk[31:1], knobs.long_press_repeat});
  endtask

  // Short times, longer times up to 3000 and the two extremes, each about a third of the time.
  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 60));
      default: return 16'($urandom_range(61, 3000));
    endcase
  endfunction

  // Sends one poll beat, with an optional idle burst before it.
  task automatic drive_poll(input logic pin, input logic [31:0] stamp);
    in_item_t beat;
    beat.pin_sample = pin;
    beat.now_ms     = stamp;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (in_stall);
    polls_sent++;
  endtask

  // Stops sending and waits until every predicted report has been taken.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (4) @(posedge clk);
  endtask

  // A realistic button press: contact bounce, a held level with rare glitches,
  // then a release level with rare glitches, its polls spaced around the filter time.
  task automatic press_sequence();
    int unsigned f;
    int unsigned span;
    int unsigned n;
    int unsigned step;
    logic        rest;
    f    = knobs.filter_ms;
    rest = knobs.idle_level;
    if ($urandom_range(0, 15) == 0) begin
      ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 3 * f + 200);
    end
    repeat ($urandom_range(0, 3)) begin
      ms_clock += $urandom_range(0, f / 2 + 1);
      drive_poll(1'($urandom_range(0, 1)), ms_clock);
    end
    span = f + 20 + (knobs.long_press_enable ?
                     knobs.long_press_ms + 4 * knobs.repeat_interval_ms : f);
    span = $urandom_range(f / 2, span);
    n    = $urandom_range(2, 14);
    step = span / n + 1;
    repeat (n) begin
      ms_clock += $urandom_range(step / 2, step + step / 2);
      drive_poll(($urandom_range(0, 11) == 0) ? rest : ~rest, ms_clock);
    end
    repeat ($urandom_range(1, 5)) begin
      ms_clock += $urandom_range(f / 2, f + f / 2 + 2);
      drive_poll(($urandom_range(0, 7) == 0) ? ~rest : rest, ms_clock);
    end
  endtask

  // Random pins with time jumps, including backward and full-range ones.
  task automatic noise_burst();
    int unsigned f;
    f = knobs.filter_ms;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 3))
        0:       ms_clock = $urandom;
        1:       ms_clock -= $urandom_range(0, 50);
        default: ms_clock += $urandom_range(0, 2 * f + 2);
      endcase
      drive_poll(1'($urandom_range(0, 1)), ms_clock);
    end
  endtask

  // Filter of zero with a single long press, then an idle level rewritten while
  // the filtered level stays put, in repeated long-press mode.
  task automatic drive_reports_and_filter_zero();
    drain_reports();
    set_knobs(1'b1, 16'd0, 16'd100, RST_REPEAT_INTERVAL, 1'b1, 1'b0);
    apply_knobs();
    drive_poll(1'b0, 32'd100);
    drive_poll(1'b0, 32'd100);
    drive_poll(1'b0, 32'd101);
    drive_poll(1'b0, 32'd250);
    drive_poll(1'b0, 32'd300);
    drive_poll(1'b1, 32'd301);
    drive_poll(1'b1, 32'd302);
    drain_reports();
    set_knobs(1'b0, 16'd0, 16'd100, 16'd10, 1'b1, 1'b1);
    apply_knobs();
    drive_poll(1'b1, 32'd400);
    drive_poll(1'b1, 32'd420);
    drive_poll(1'b1, 32'd425);
    drive_poll(1'b1, 32'd431);
    drive_poll(1'b0, 32'd500);
    drive_poll(1'b0, 32'd501);
    drain_reports();
  endtask

  initial begin
    int unsigned quota_end;
    set_knobs(RST_IDLE_LEVEL, RST_FILTER_MS, RST_LONG_PRESS_MS, RST_REPEAT_INTERVAL,
              RST_LONG_PRESS_EN, RST_LONG_PRESS_REP);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct   = 20;
    stall_pct = 20;

    // Reset settings: press with click, a held glitch accepted at once on the
    // next differing poll, a glitch dropped at rest, and a press across the wrap.
    drive_poll(1'b1, 32'd0);
    drive_poll(1'b0, 32'd5);
    drive_poll(1'b0, 32'd30);
    drive_poll(1'b0, 32'd40);
    drive_poll(1'b1, 32'd50);
    drive_poll(1'b0, 32'd80);
    drive_poll(1'b1, 32'd81);
    drive_poll(1'b0, 32'd90);
    drive_poll(1'b1, 32'd200);
    drive_poll(1'b0, 32'hFFFF_FFF0);
    drive_poll(1'b0, 32'h0000_0010);
    drive_poll(1'b1, 32'h0000_0011);
    drive_poll(1'b1, 32'h0000_0040);
    drive_reports_and_filter_zero();

    // Random phases; the first few pin the registers to their extremes.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       set_knobs(1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
        1:       set_knobs(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        2:       set_knobs(1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 1'b1);
        3:       set_knobs(1'b1, 16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1);
        default: set_knobs(1'($urandom_range(0, 1)), pick_ms(), pick_ms(), pick_ms(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      apply_knobs();
      if (phase == PhaseCount - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 2) * 20;
        stall_pct = $urandom_range(0, 2) * 20;
      end
      quota_end = polls_sent + PhasePolls;
      while (polls_sent < quota_end) begin
        if ($urandom_range(0, 9) < 7) begin
          press_sequence();
        end else begin
          noise_burst();
        end
      end
      drain_reports();
    end

    if (fail_count == 0 && reports_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
